>>> rtl/core/frx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frx_pkg: shared definitions of the firmware image receiver
// Command and status codes, CRC32 constants and the item and result structs.
// ----------------------------------------------------------------------------
package frx_pkg;

  // Largest image in bytes that the buffer holds.
  localparam int unsigned FRX_MAX_IMAGE_BYTES = 32'd65536;

  // Reflected CRC32 as used by zlib.
  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_IGNORE = 2'd3
  } frx_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READY = 2'd1,
    ST_ERROR = 2'd2,
    ST_DONE  = 2'd3
  } frx_status_t;

  typedef struct packed {
    frx_cmd_t    cmd;
    logic [31:0] image_size;
    logic [31:0] image_crc;
    logic        header_complete;
    logic [7:0]  data_byte;
  } frx_item_t;

  typedef struct packed {
    frx_status_t status;
    logic [16:0] bytes_received;
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_byte;
  } frx_result_t;

endpackage
`default_nettype wire

>>> rtl/core/frx_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frx_in_if: input channel of the firmware image receiver
// Valid/ready channel carrying one command item per transfer.
// ----------------------------------------------------------------------------
interface frx_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] image_size;
  logic [31:0] image_crc;
  logic        header_complete;
  logic [7:0]  data_byte;

  modport source (
    output valid, cmd, image_size, image_crc, header_complete, data_byte,
    input  ready
  );

  modport sink (
    input  valid, cmd, image_size, image_crc, header_complete, data_byte,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/core/frx_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frx_out_if: result channel of the firmware image receiver
// Valid/ready channel carrying one status and buffer write per transfer.
// ----------------------------------------------------------------------------
interface frx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [16:0] bytes_received;
  logic        write_enable;
  logic [15:0] write_address;
  logic [7:0]  write_byte;

  modport source (
    output valid, status, bytes_received, write_enable, write_address, write_byte,
    input  ready
  );

  modport sink (
    input  valid, status, bytes_received, write_enable, write_address, write_byte,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/core/firmware_image_receiver_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// firmware_image_receiver_top: CRC32-checked firmware image download
// Takes begin, data and finish items, issues image buffer writes and reports
// the download status and byte count for every item.
// ----------------------------------------------------------------------------
// An item passes through the input register and then the result register
// before its result is shown on the result channel.
// Throughput: one item per cycle while the result side takes results, set by
// the single-pass byte CRC network between the input and result registers.
// Reset: synchronous; empties both registers, sets the status to idle, the
// count and size to zero and the running CRC to all ones.
module firmware_image_receiver_top
  import frx_pkg::*;
#(
  parameter int unsigned MAX_IMAGE_BYTES = FRX_MAX_IMAGE_BYTES
) (
  input  wire logic clk,
  input  wire logic rst,
  frx_in_if.sink    item_in,
  frx_out_if.source result_out
);

  // Input register: holds one item while its result is formed. It is
  // refilled in the same cycle as it moves on, so transfers run back to back.
  logic      item_valid;
  frx_item_t item_reg;

  // Result register: parts the two sides, so a new item can be taken in
  // while the previous result still waits for the sink.
  logic        res_valid;
  frx_result_t res_reg;
  frx_result_t res_next;

  // The registered item is processed, and the state committed, only when
  // the result register is free or is being emptied in this cycle.
  logic advance;

  assign advance       = item_valid && (!res_valid || result_out.ready);
  assign item_in.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_in.ready) begin
      item_valid <= item_in.valid;
    end
  end

  // The command field starts out as the ignored command, so the decoder in
  // the core never sees an unknown command before the first transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_reg.cmd <= CMD_IGNORE;
    end else if (item_in.valid && item_in.ready) begin
      item_reg.cmd             <= frx_cmd_t'(item_in.cmd);
      item_reg.image_size      <= item_in.image_size;
      item_reg.image_crc       <= item_in.image_crc;
      item_reg.header_complete <= item_in.header_complete;
      item_reg.data_byte       <= item_in.data_byte;
    end
  end

  // The core holds the download state and works out each item's result.
  frx_core #(
    .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item_reg),
    .result  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || result_out.ready) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= res_next;
    end
  end

  assign result_out.valid          = res_valid;
  assign result_out.status         = res_reg.status;
  assign result_out.bytes_received = res_reg.bytes_received;
  assign result_out.write_enable   = res_reg.write_enable;
  assign result_out.write_address  = res_reg.write_address;
  assign result_out.write_byte     = res_reg.write_byte;

  // A buffer write is only issued while a download is in progress.
  a_write_needs_ready: assert property (
    @(posedge clk) disable iff (rst)
    (result_out.valid && result_out.write_enable) |->
      (result_out.status == ST_READY)
  ) else $error("buffer write reported outside the ready status");

  // The write offset is the count before the byte was added.
  a_write_address_follows_count: assert property (
    @(posedge clk) disable iff (rst)
    (result_out.valid && result_out.write_enable) |->
      (result_out.write_address == 16'(result_out.bytes_received - 17'd1))
  ) else $error("write address does not match the byte count");

  // With no write, the address and byte fields are zero.
  a_idle_write_fields_zero: assert property (
    @(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.write_enable) |->
      (result_out.write_address == 16'd0 && result_out.write_byte == 8'd0)
  ) else $error("write fields not cleared without a write");

  // The input side is never stalled while the input register is empty.
  a_ready_when_empty: assert property (
    @(posedge clk) disable iff (rst)
    !item_valid |-> item_in.ready
  ) else $error("input stalled with an empty input register");

endmodule
`default_nettype wire

>>> rtl/core/frx_crc_byte.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frx_crc_byte: one-byte update of a reflected CRC32
// Eight shift-and-reduce steps unrolled into a single XOR network.
// ----------------------------------------------------------------------------
module frx_crc_byte
  import frx_pkg::*;
(
  input  wire logic [31:0] crc_in,
  input  wire logic [7:0]  data,
  output logic      [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    crc_out = c;
  end

endmodule
`default_nettype wire

>>> rtl/core/frx_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frx_core: download state and per-item decision logic
// Holds status, size, expected CRC, byte count and running CRC, and forms
// the result of the registered item in the same cycle.
// ----------------------------------------------------------------------------
module frx_core
  import frx_pkg::*;
#(
  parameter int unsigned MAX_IMAGE_BYTES = FRX_MAX_IMAGE_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire frx_item_t   item,
  output frx_result_t      result
);

  localparam int unsigned CNT_W = $clog2(MAX_IMAGE_BYTES + 1);

  frx_status_t      load_status, load_status_next;
  logic [CNT_W-1:0] total_bytes, total_bytes_next;
  logic [31:0]      expected_check, expected_check_next;
  logic [CNT_W-1:0] received_count, received_count_next;
  logic [31:0]      running_check, running_check_next;
  logic [31:0]      crc_updated;

  frx_crc_byte u_crc (
    .crc_in  (running_check),
    .data    (item.data_byte),
    .crc_out (crc_updated)
  );

  always_comb begin
    load_status_next    = load_status;
    total_bytes_next    = total_bytes;
    expected_check_next = expected_check;
    received_count_next = received_count;
    running_check_next  = running_check;
    result.write_enable  = 1'b0;
    result.write_address = 16'd0;
    result.write_byte    = 8'd0;

    unique case (item.cmd)
      CMD_BEGIN: begin
        if (!item.header_complete || item.image_size == 32'd0 ||
            item.image_size > 32'(MAX_IMAGE_BYTES)) begin
          load_status_next = ST_ERROR;
        end else begin
          total_bytes_next    = CNT_W'(item.image_size);
          expected_check_next = item.image_crc;
          received_count_next = '0;
          running_check_next  = CRC_PRESET;
          load_status_next    = ST_READY;
        end
      end
      CMD_DATA: begin
        if (load_status == ST_READY && received_count < total_bytes) begin
          result.write_enable  = 1'b1;
          result.write_address = 16'(received_count);
          result.write_byte    = item.data_byte;
          running_check_next   = crc_updated;
          received_count_next  = received_count + CNT_W'(1);
        end
      end
      CMD_FINISH: begin
        if (load_status != ST_READY || received_count != total_bytes) begin
          load_status_next = ST_ERROR;
        end else if (expected_check != 32'd0 &&
                     (running_check ^ CRC_PRESET) != expected_check) begin
          load_status_next = ST_ERROR;
        end else begin
          load_status_next = ST_DONE;
        end
      end
      CMD_IGNORE: begin
      end
    endcase

    result.status         = load_status_next;
    result.bytes_received = 17'(received_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_status    <= ST_IDLE;
      total_bytes    <= '0;
      expected_check <= 32'd0;
      received_count <= '0;
      running_check  <= CRC_PRESET;
    end else if (advance) begin
      load_status    <= load_status_next;
      total_bytes    <= total_bytes_next;
      expected_check <= expected_check_next;
      received_count <= received_count_next;
      running_check  <= running_check_next;
    end
  end

endmodule
`default_nettype wire

>>> bench/frx_checker.sv
// ----------------------------------------------------------------------------
// frx_checker: scoreboard for the firmware image receiver
// Watches both channels, keeps its own copy of the download state, works out
// the result that each transfer on the item channel must produce and compares
// every transfer on the result channel with the oldest outstanding one.
// ----------------------------------------------------------------------------
module frx_checker
  import frx_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  frx_in_if         item_ch,
  frx_out_if        result_ch,
  output int        errors,
  output int        pending
);

  // Shadow of the download state.
  frx_status_t load_state;
  logic [16:0] image_len;
  logic [31:0] crc_expected;
  logic [16:0] byte_count;
  logic [31:0] crc_running;

  frx_result_t awaited_results[$];
  int          results_seen;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    int          k;
    c = crc ^ {24'h0, b};
    for (k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Applies one item to the shadow state and returns the result it produces.
  function automatic frx_result_t download_result(input frx_item_t it);
    frx_result_t r;
    r = '0;
    case (it.cmd)
      CMD_BEGIN: begin
        if (!it.header_complete || it.image_size == 0 ||
            it.image_size > FRX_MAX_IMAGE_BYTES) begin
          load_state = ST_ERROR;
        end else begin
          image_len    = it.image_size[16:0];
          crc_expected = it.image_crc;
          byte_count   = '0;
          crc_running  = CRC_PRESET;
          load_state   = ST_READY;
        end
      end
      CMD_DATA: begin
        if (load_state == ST_READY && byte_count < image_len) begin
          r.write_enable  = 1'b1;
          r.write_address = byte_count[15:0];
          r.write_byte    = it.data_byte;
          crc_running     = crc32_byte(crc_running, it.data_byte);
          byte_count      = byte_count + 17'd1;
        end
      end
      CMD_FINISH: begin
        if (load_state != ST_READY || byte_count != image_len) begin
          load_state = ST_ERROR;
        end else if (crc_expected != 0 && (crc_running ^ CRC_PRESET) != crc_expected) begin
          load_state = ST_ERROR;
        end else begin
          load_state = ST_DONE;
        end
      end
      default: ;
    endcase
    r.status         = load_state;
    r.bytes_received = byte_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 40) begin
      $display("%0t: result %0d: %s is %0h, predicted %0h", $time, results_seen, what, got,
               want);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    frx_item_t   it;
    frx_result_t want;
    if (rst) begin
      load_state   = ST_IDLE;
      image_len    = '0;
      crc_expected = '0;
      byte_count   = '0;
      crc_running  = CRC_PRESET;
      awaited_results.delete();
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(result_ch.status), 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (result_ch.status !== want.status)
            report_mismatch("status", 32'(result_ch.status), 32'(want.status));
          if (result_ch.bytes_received !== want.bytes_received)
            report_mismatch("bytes_received", 32'(result_ch.bytes_received),
                            32'(want.bytes_received));
          if (result_ch.write_enable !== want.write_enable)
            report_mismatch("write_enable", 32'(result_ch.write_enable),
                            32'(want.write_enable));
          if (result_ch.write_address !== want.write_address)
            report_mismatch("write_address", 32'(result_ch.write_address),
                            32'(want.write_address));
          if (result_ch.write_byte !== want.write_byte)
            report_mismatch("write_byte", 32'(result_ch.write_byte), 32'(want.write_byte));
        end
        results_seen++;
      end
      if (item_ch.valid && item_ch.ready) begin
        it.cmd             = frx_cmd_t'(item_ch.cmd);
        it.image_size      = item_ch.image_size;
        it.image_crc       = item_ch.image_crc;
        it.header_complete = item_ch.header_complete;
        it.data_byte       = item_ch.data_byte;
        awaited_results.push_back(download_result(it));
      end
    end
    pending <= awaited_results.size();
  end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the firmware image receiver
// Drives begin, data, finish and ignored items into the receiver with random
// idling on both channels; the checker beside the block predicts every
// result and counts mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import frx_pkg::*;

  // Kinds of expected CRC that a begin item may announce.
  typedef enum {CHECK_GOOD, CHECK_OFF, CHECK_WRONG} check_mode_t;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 850;

  logic clk = 1'b0;
  logic rst;

  frx_in_if  item_ch ();
  frx_out_if result_ch ();

  int          fails;
  int          waiting;
  int unsigned cycle_count;
  int unsigned useful_items;
  bit          quiet;

  always #10 clk = ~clk;

  firmware_image_receiver_top DUT (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_ch),
    .result_out (result_ch)
  );

  frx_checker checker_u (
    .clk       (clk),
    .rst       (rst),
    .item_ch   (item_ch),
    .result_ch (result_ch),
    .errors    (fails),
    .pending   (waiting)
  );

  // A hung block must not keep the run going for ever. The limit sits far
  // above the slowest correct run, with every transfer meeting the longest
  // idle burst on both sides.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The CRC here is only used to make begin items announce the right value
  // for the bytes that follow; it plays no part in the checking.
  function automatic logic [31:0] image_crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    int          k;
    c = crc ^ {24'h0, b};
    for (k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Every field is random, so that fields which the command does not use
  // still see all their bits toggle.
  function automatic frx_item_t rand_item(input frx_cmd_t c);
    frx_item_t it;
    it.cmd             = c;
    it.image_size      = $urandom();
    it.image_crc       = $urandom();
    it.header_complete = 1'($urandom_range(0, 1));
    it.data_byte       = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic frx_item_t begin_item(input logic [31:0] size, input logic [31:0] crc,
                                           input logic hdr);
    frx_item_t it;
    it                 = rand_item(CMD_BEGIN);
    it.image_size      = size;
    it.image_crc       = crc;
    it.header_complete = hdr;
    return it;
  endfunction

  function automatic frx_item_t data_item(input logic [7:0] b);
    frx_item_t it;
    it           = rand_item(CMD_DATA);
    it.data_byte = b;
    return it;
  endfunction

  // Presents one item and returns at the edge where it is transferred. Valid
  // stays high afterwards, so back-to-back items need no second assignment
  // in the same step; an idle burst lowers it first.
  task automatic send(input frx_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    item_ch.valid           <= 1'b1;
    item_ch.cmd             <= it.cmd;
    item_ch.image_size      <= it.image_size;
    item_ch.image_crc       <= it.image_crc;
    item_ch.header_complete <= it.header_complete;
    item_ch.data_byte       <= it.data_byte;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (it.cmd != CMD_IGNORE) useful_items++;
  endtask

  // Stops sending and waits until the checker has no result outstanding. The
  // first edge lets an item transferred in this very step reach the count.
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  // One download: a begin item announcing 'announced' bytes, 'nbytes' data
  // items and optionally a finish. The announced CRC covers the bytes up to
  // the announced size, so extra bytes must be dropped for the check to pass.
  task automatic send_image(input int unsigned announced, input int unsigned nbytes,
                            input check_mode_t mode, input bit finish_it, input bit noisy);
    logic [7:0]  img[];
    logic [31:0] crc;
    img = new[nbytes];
    crc = CRC_PRESET;
    foreach (img[i]) begin
      img[i] = 8'($urandom_range(0, 255));
      if (i < announced) crc = image_crc_step(crc, img[i]);
    end
    crc = crc ^ CRC_PRESET;
    if (mode == CHECK_OFF) begin
      crc = '0;
    end else if (mode == CHECK_WRONG) begin
      crc = crc ^ ($urandom() | 32'h1);
    end
    send(begin_item(announced, crc, 1'b1));
    foreach (img[i]) begin
      if (noisy && $urandom_range(0, 7) == 0) send(rand_item(CMD_IGNORE));
      send(data_item(img[i]));
    end
    if (finish_it) send(rand_item(CMD_FINISH));
  endtask

  // The result side holds ready high for random stretches and drops it for
  // random bursts, except in the quiet closing part of the run.
  initial begin
    result_ch.ready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        result_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned size;
    int unsigned nbytes;
    int unsigned goal;
    int unsigned pick;
    bit          drained_mid;
    check_mode_t mode;
    frx_cmd_t    stray;
    logic [31:0] dir_crc;

    rst                     <= 1'b1;
    item_ch.valid           <= 1'b0;
    item_ch.cmd             <= CMD_IGNORE;
    item_ch.image_size      <= '0;
    item_ch.image_crc       <= '0;
    item_ch.header_complete <= 1'b0;
    item_ch.data_byte       <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Out of reset the block is idle: a byte is ignored and a
    // finish turns into an error.
    send(data_item(8'h00));
    send(rand_item(CMD_IGNORE));
    send(rand_item(CMD_FINISH));

    // Rejected begin items: short header, zero size, one past the buffer and
    // the largest size the field can carry.
    send(begin_item(32'd16, 32'h0, 1'b0));
    send(begin_item(32'd0, 32'h0, 1'b1));
    send(begin_item(FRX_MAX_IMAGE_BYTES + 1, 32'h0, 1'b1));
    send(begin_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));

    // A three-byte image with the correct CRC and one surplus byte, which
    // must be dropped without a buffer write.
    dir_crc = image_crc_step(image_crc_step(image_crc_step(CRC_PRESET, 8'h00), 8'hFF), 8'hA5)
              ^ CRC_PRESET;
    send(begin_item(32'd3, dir_crc, 1'b1));
    send(data_item(8'h00));
    send(data_item(8'hFF));
    send(data_item(8'hA5));
    send(data_item(8'h3C));
    send(rand_item(CMD_IGNORE));
    send(rand_item(CMD_FINISH));
    send(data_item(8'h77));

    // A begin restarts from done; a zero CRC switches the check off.
    send(begin_item(32'd1, 32'h0, 1'b1));
    send(data_item(8'hFF));
    send(rand_item(CMD_FINISH));

    // Finish with too few bytes, then the largest accepted image cut short,
    // then a finish while already in error.
    send(begin_item(32'd2, 32'hFFFF_FFFF, 1'b1));
    send(data_item(8'h00));
    send(rand_item(CMD_FINISH));
    send(begin_item(FRX_MAX_IMAGE_BYTES, 32'h0000_0001, 1'b1));
    send(data_item(8'hFF));
    send(rand_item(CMD_FINISH));
    send(rand_item(CMD_FINISH));

    // The sender holds off once here until every result has come back.
    drain();

    // Random part: mostly well-formed downloads with random content, the
    // rest rejected begins, stray items, abandoned downloads and the largest
    // image size. The final stretch runs without idling.
    goal        = useful_items + RANDOM_ITEMS;
    drained_mid = 1'b0;
    while (useful_items < goal) begin
      if (useful_items + 150 >= goal) quiet = 1'b1;
      if (!drained_mid && useful_items + RANDOM_ITEMS / 2 >= goal) begin
        drain();
        drained_mid = 1'b1;
      end
      pick = $urandom_range(0, 99);
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
      if (pick < 70) begin
        case ($urandom_range(0, 9))
          0, 1:    mode = CHECK_OFF;
          2, 3:    mode = CHECK_WRONG;
          default: mode = CHECK_GOOD;
        endcase
        case ($urandom_range(0, 7))
          0:       nbytes = size - $urandom_range(1, (size < 3) ? size : 3);
          1:       nbytes = size + $urandom_range(1, 3);
          default: nbytes = size;
        endcase
        send_image(size, nbytes, mode, 1'b1, $urandom_range(0, 3) == 0);
      end else if (pick < 80) begin
        case ($urandom_range(0, 3))
          0:       send(begin_item($urandom_range(1, FRX_MAX_IMAGE_BYTES), $urandom(), 1'b0));
          1:       send(begin_item(32'd0, $urandom(), 1'b1));
          2:       send(begin_item($urandom_range(FRX_MAX_IMAGE_BYTES + 1, 32'hFFFF_FFFF),
                                   $urandom(), 1'b1));
          default: send(rand_item(CMD_BEGIN));
        endcase
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 2))
            0:       stray = CMD_DATA;
            1:       stray = CMD_FINISH;
            default: stray = CMD_IGNORE;
          endcase
          send(rand_item(stray));
        end
      end else if (pick < 96) begin
        // Abandoned download: the next begin restarts it.
        send_image(size, $urandom_range(0, size - 1), CHECK_GOOD, 1'b0, 1'b1);
      end else begin
        send_image(FRX_MAX_IMAGE_BYTES, $urandom_range(0, 20), CHECK_GOOD, 1'b1, 1'b0);
      end
    end

    // Wait for the last results, then watch on for anything the block should not have sent.
    drain();
    repeat (8) @(posedge clk);
    if (fails == 0 && waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
